// File: src/mhpq_pkg.sv
// mhpq_pkg: shared types and codes of the max-heap priority queue
// no dependencies; used by every module of the project
`default_nettype none

package mhpq_pkg;

	// request opcodes
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic ext;
	} mhpq_cmd_t;

endpackage

`default_nettype wire

// File: src/mhpq_cell.sv
// mhpq_cell: one slot of the sorted key row, largest key at the left end
// depends on mhpq_pkg for the command struct
`default_nettype none

module mhpq_cell #(
	parameter int KEY_WIDTH = 16
) (
	input  wire                   clk,
	input  mhpq_pkg::mhpq_cmd_t   cmd,
	input  wire  [KEY_WIDTH-1:0]  key,
	input  wire                   occ,
	input  wire  [KEY_WIDTH-1:0]  left_val,
	input  wire                   left_ge,
	input  wire  [KEY_WIDTH-1:0]  right_val,
	output logic [KEY_WIDTH-1:0]  val,
	output logic                  ge
);

	logic [KEY_WIDTH-1:0] val_q;

	// this slot holds a key not below the incoming one
	assign ge  = occ && (val_q >= key);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (ge) begin
				val_q <= val_q;
			end else if (left_ge) begin
				val_q <= key;
			end else begin
				val_q <= left_val;
			end
		end else if (cmd.ext) begin
			val_q <= right_val;
		end
	end

endmodule

`default_nettype wire

// File: src/max_heap_priority_queue_unit.sv
// max_heap_priority_queue_unit: top level of the max-heap priority queue
// depends on mhpq_pkg and mhpq_cell
//
// usage
//   request channel: in_valid/in_ready with opcode and key_value; opcode insert
//   stores key_value, opcode extract removes the largest stored key
//   result channel: out_valid/out_ready with status, popped_value, max_value,
//   min_value, entry_count and is_empty, one result per request, in order
// result timing and throughput
//   a result appears in the cycle after its request is taken; one request a
//   cycle is sustained while results are taken, since the whole cell row
//   shifts or inserts all at once
// storage
//   the keys sit in a row of CAPACITY cells kept in descending order; an insert
//   opens a gap at the sorted position and the smaller keys move one cell right,
//   an extract moves every key one cell left; the fill count marks which cells
//   are in use, so there is no clearing pass
// reset
//   arst_n empties the queue and drops any pending result; the running
//   minimum returns to zero
// stall
//   while a result waits and out_ready is low, in_ready stays low and the
//   result holds; a new request is taken in the same cycle the old result goes
`default_nettype none

module max_heap_priority_queue_unit #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 16,
	localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  opcode,
	input  wire  [KEY_WIDTH-1:0] key_value,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [1:0]           status,
	output logic [KEY_WIDTH-1:0] popped_value,
	output logic [KEY_WIDTH-1:0] max_value,
	output logic [KEY_WIDTH-1:0] min_value,
	output logic [CNT_W-1:0]     entry_count,
	output logic                 is_empty
);

	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// control state
	logic                 out_valid_q;
	logic [CNT_W-1:0]     count_q;
	logic [KEY_WIDTH-1:0] min_q;

	// result register
	logic [1:0]           status_q;
	logic [KEY_WIDTH-1:0] popped_q;
	logic [KEY_WIDTH-1:0] max_q;
	logic [KEY_WIDTH-1:0] rmin_q;
	logic [CNT_W-1:0]     rcount_q;

	// cell row
	logic [KEY_WIDTH-1:0] cell_val [CAPACITY];
	logic                 cell_ge  [CAPACITY];
	mhpq_pkg::mhpq_cmd_t  cmd;

	logic                 take;
	logic                 empty_now;
	logic                 full_now;
	logic [1:0]           status_d;
	logic [KEY_WIDTH-1:0] popped_d;
	logic [KEY_WIDTH-1:0] max_d;
	logic [KEY_WIDTH-1:0] min_d;
	logic [CNT_W-1:0]     count_d;

	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign empty_now = (count_q == '0);
	assign full_now  = (count_q >= CAP_C);

	// decide the operation and the result seen after it
	always_comb begin
		cmd      = '0;
		status_d = mhpq_pkg::ST_OK;
		popped_d = '0;
		max_d    = '0;
		min_d    = min_q;
		count_d  = count_q;
		if (opcode == mhpq_pkg::OP_INSERT) begin
			if (full_now) begin
				status_d = mhpq_pkg::ST_FULL;
				max_d    = cell_val[0];
			end else begin
				cmd.ins = take;
				count_d = count_q + 1'b1;
				// the new root is the larger of old root and key
				if (empty_now || (key_value > cell_val[0])) begin
					max_d = key_value;
				end else begin
					max_d = cell_val[0];
				end
				if (empty_now || (key_value < min_q)) begin
					min_d = key_value;
				end
			end
		end else begin
			if (empty_now) begin
				status_d = mhpq_pkg::ST_EMPTY;
			end else begin
				cmd.ext  = take;
				popped_d = cell_val[0];
				count_d  = count_q - 1'b1;
				// second largest key becomes the root, or zero once the queue is empty
				if (count_q > CNT_W'(1)) begin
					max_d = cell_val[1];
				end else begin
					max_d = '0;
					min_d = '0;
				end
			end
		end
	end

	// cell row: left end sees an unbounded key, right end repeats itself
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [KEY_WIDTH-1:0] lv;
		logic                 lg;
		logic [KEY_WIDTH-1:0] rv;
		logic                 occ;

		assign occ = (count_q > CNT_W'(g));

		if (g == 0) begin : g_first
			assign lv = key_value;
			assign lg = 1'b1;
		end else begin : g_mid
			assign lv = cell_val[g-1];
			assign lg = cell_ge[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign rv = cell_val[g];
		end else begin : g_body
			assign rv = cell_val[g+1];
		end

		mhpq_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.key      (key_value),
			.occ      (occ),
			.left_val (lv),
			.left_ge  (lg),
			.right_val(rv),
			.val      (cell_val[g]),
			.ge       (cell_ge[g])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			min_q       <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				count_q     <= count_d;
				min_q       <= min_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
			popped_q <= popped_d;
			max_q    <= max_d;
			rmin_q   <= (count_d == '0) ? '0 : min_d;
			rcount_q <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign max_value    = max_q;
	assign min_value    = rmin_q;
	assign entry_count  = rcount_q;
	assign is_empty     = (rcount_q == '0);

endmodule

`default_nettype wire

// File: src/mhpq_checker.sv
// mhpq_checker: port-level assertions for max_heap_priority_queue_unit
// depends on mhpq_pkg for status codes; bound to the top level below
`default_nettype none

module mhpq_checker #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 16,
	localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire [1:0]           status,
	input wire [KEY_WIDTH-1:0] popped_value,
	input wire [KEY_WIDTH-1:0] max_value,
	input wire [KEY_WIDTH-1:0] min_value,
	input wire [CNT_W-1:0]     entry_count,
	input wire                 is_empty
);

	// stalled result stays valid and keeps its maximum and count
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(max_value) && $stable(entry_count))
		else $error("result changed while stalled");

	// an empty queue reports zero extremes
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> max_value == '0 && min_value == '0)
		else $error("empty queue with nonzero extremes");

	// minimum never above maximum
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_empty |-> min_value <= max_value)
		else $error("minimum above maximum");

	// popped key dominates what remains, a dropped insert means full
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mhpq_pkg::ST_OK |-> popped_value == '0 ||
			popped_value >= max_value)
		else $error("popped key below new maximum");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mhpq_pkg::ST_FULL |-> entry_count == CNT_W'(CAPACITY))
		else $error("insert dropped while not full");

endmodule

bind max_heap_priority_queue_unit mhpq_checker #(
	.CAPACITY (CAPACITY),
	.KEY_WIDTH(KEY_WIDTH)
) u_mhpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.popped_value(popped_value),
	.max_value   (max_value),
	.min_value   (min_value),
	.entry_count (entry_count),
	.is_empty    (is_empty)
);

`default_nettype wire

// File: tb/tb_max_heap_priority_queue_unit.sv
// tb_max_heap_priority_queue_unit: self-checking bench for the max-heap priority queue
// depends on mhpq_pkg and max_heap_priority_queue_unit; a local heap predicts every result
// directed table, random insert/extract traffic, a drain past empty, more random traffic
`default_nettype none

module tb_max_heap_priority_queue_unit;

	localparam int CAPACITY    = 1024;
	localparam int KEY_W       = 16;
	localparam int CNT_W       = 11;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 60;

	// one result of the queue, as seen on the result channel
	typedef struct packed {
		logic [1:0]       status;
		logic [KEY_W-1:0] pop_key;
		logic [KEY_W-1:0] top_key;
		logic [KEY_W-1:0] floor_key;
		logic [CNT_W-1:0] count;
		logic             empty;
	} queue_result_t;

	// one row of the directed table; typed rows carry their own answer
	typedef struct {
		logic          op;
		logic [KEY_W-1:0] key;
		bit            typed;
		queue_result_t res;
	} request_row_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic             opcode;
	logic [KEY_W-1:0] key_value;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic [KEY_W-1:0] popped_value;
	logic [KEY_W-1:0] max_value;
	logic [KEY_W-1:0] min_value;
	logic [CNT_W-1:0] entry_count;
	logic             is_empty;

	// predictor state: array heap, fill level and running minimum
	logic [KEY_W-1:0] heap_keys [CAPACITY];
	int               heap_fill;
	logic [KEY_W-1:0] heap_floor;

	queue_result_t    pending_results[$];
	request_row_t     directed_rows[$];

	int  error_count;
	int  cycle_count;
	int  requests_sent;
	int  results_seen;
	int  full_drops;
	int  empty_pops;
	int  stall_left;
	bit  burst_mode;

	max_heap_priority_queue_unit #(
		.CAPACITY (CAPACITY),
		.KEY_WIDTH(KEY_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.key_value   (key_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.popped_value(popped_value),
		.max_value   (max_value),
		.min_value   (min_value),
		.entry_count (entry_count),
		.is_empty    (is_empty)
	);

	// 20-unit clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// heap predictor: applies one request and returns the result it causes
	function automatic queue_result_t apply_request(logic op, logic [KEY_W-1:0] key);
		queue_result_t    r;
		int               pos;
		int               up;
		int               lc;
		int               rc;
		int               big;
		bit               settled;
		logic [KEY_W-1:0] tmp;
		r = '0;
		r.status = mhpq_pkg::ST_OK;
		if (op == mhpq_pkg::OP_INSERT) begin
			if (heap_fill >= CAPACITY) begin
				// full: key is dropped, heap untouched
				r.status = mhpq_pkg::ST_FULL;
			end else begin
				// first key after empty always sets the floor
				if (heap_fill == 0 || key < heap_floor)
					heap_floor = key;
				heap_keys[heap_fill] = key;
				pos = heap_fill;
				heap_fill++;
				// sift up only past a strictly smaller parent
				settled = 1'b0;
				while (pos > 0 && !settled) begin
					up = (pos - 1) / 2;
					if (heap_keys[pos] <= heap_keys[up]) begin
						settled = 1'b1;
					end else begin
						tmp = heap_keys[pos];
						heap_keys[pos] = heap_keys[up];
						heap_keys[up] = tmp;
						pos = up;
					end
				end
			end
		end else begin
			if (heap_fill == 0) begin
				r.status = mhpq_pkg::ST_EMPTY;
			end else begin
				r.pop_key = heap_keys[0];
				heap_fill--;
				heap_keys[0] = heap_keys[heap_fill];
				if (heap_fill == 0)
					heap_floor = '0;
				// sift down, left child wins a tie between children
				pos = 0;
				settled = (heap_fill == 0);
				while (!settled) begin
					lc = 2 * pos + 1;
					rc = 2 * pos + 2;
					big = pos;
					if (lc < heap_fill && heap_keys[lc] > heap_keys[big])
						big = lc;
					if (rc < heap_fill && heap_keys[rc] > heap_keys[big])
						big = rc;
					if (big == pos) begin
						settled = 1'b1;
					end else begin
						tmp = heap_keys[pos];
						heap_keys[pos] = heap_keys[big];
						heap_keys[big] = tmp;
						pos = big;
					end
				end
			end
		end
		r.top_key   = (heap_fill != 0) ? heap_keys[0] : '0;
		r.floor_key = (heap_fill != 0) ? heap_floor : '0;
		r.count     = heap_fill[CNT_W-1:0];
		r.empty     = (heap_fill == 0);
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (burst_mode)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// keys lean on the extremes and on a small pool so ties are common
	function automatic logic [KEY_W-1:0] pick_key();
		int               roll;
		logic [KEY_W-1:0] k;
		roll = $urandom_range(0, 99);
		k = KEY_W'($urandom);
		if (roll < 8)
			k = '0;
		else if (roll < 16)
			k = '1;
		else if (roll < 32)
			k = KEY_W'($urandom_range(0, 7));
		else if (roll < 40)
			k = {1'b1, {(KEY_W-3){1'b0}}, 2'(k)};
		return k;
	endfunction

	// append one row to the directed table
	task automatic add_row(logic op, logic [KEY_W-1:0] key, bit typed,
		logic [1:0] st, logic [KEY_W-1:0] pop, logic [KEY_W-1:0] top,
		logic [KEY_W-1:0] floor_k, int cnt, logic emp);
		request_row_t row;
		row.op            = op;
		row.key           = key;
		row.typed         = typed;
		row.res.status    = st;
		row.res.pop_key   = pop;
		row.res.top_key   = top;
		row.res.floor_key = floor_k;
		row.res.count     = CNT_W'(cnt);
		row.res.empty     = emp;
		directed_rows = {directed_rows, row};
	endtask

	// drive one request, hold it until taken, then record what it should produce
	task automatic send_request(logic op, logic [KEY_W-1:0] key, bit typed,
		queue_result_t typed_res);
		int            gap;
		queue_result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		key_value <= key;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// taken at this edge; predictor always advances, typed rows override its answer
		predicted = apply_request(op, key);
		if (typed)
			pending_results = {pending_results, typed_res};
		else
			pending_results = {pending_results, predicted};
		requests_sent++;
	endtask

	task automatic send_random(int insert_pct);
		logic op;
		op = ($urandom_range(0, 99) < insert_pct) ? mhpq_pkg::OP_INSERT :
			mhpq_pkg::OP_EXTRACT;
		send_request(op, pick_key(), 1'b0, '0);
	endtask

	// mixed traffic in bursts that lean toward growth, shrinkage or balance
	task automatic run_mixed(int n_items);
		int done_items;
		int len;
		int pct;
		int k;
		done_items = 0;
		while (done_items < n_items) begin
			len = $urandom_range(1, 30);
			case ($urandom_range(0, 2))
				0: pct = 75;
				1: pct = 25;
				default: pct = 50;
			endcase
			for (k = 0; k < len && done_items < n_items; k++) begin
				send_random(pct);
				done_items++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (error_count < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want,
					got);
			error_count++;
		end
	endtask

	// result side: random back-pressure and in-order comparison
	always @(posedge clk) begin : result_side
		queue_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$display("%0t: unexpected result, expected none, actual status %0h",
							$time, status);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", want.status, status);
					check_field("popped_value", want.pop_key, popped_value);
					check_field("max_value", want.top_key, max_value);
					check_field("min_value", want.floor_key, min_value);
					check_field("entry_count", want.count, entry_count);
					check_field("is_empty", want.empty, is_empty);
					results_seen++;
					if (want.status == mhpq_pkg::ST_FULL)
						full_drops++;
					if (want.status == mhpq_pkg::ST_EMPTY)
						empty_pops++;
				end
			end
			// stall pattern for the next cycle
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int i;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		opcode    <= mhpq_pkg::OP_INSERT;
		key_value <= '0;
		out_ready <= 1'b0;
		error_count   = 0;
		cycle_count   = 0;
		requests_sent = 0;
		results_seen  = 0;
		full_drops    = 0;
		empty_pops    = 0;
		stall_left    = 0;
		burst_mode    = 1'b0;
		heap_fill     = 0;
		heap_floor    = '0;

		// directed table: empty extract, key extremes, first insert, ties, drain
		add_row(mhpq_pkg::OP_EXTRACT, 16'hFFFF, 1, mhpq_pkg::ST_EMPTY, 0, 0, 0, 0, 1);
		add_row(mhpq_pkg::OP_INSERT, 16'hFFFF, 1, mhpq_pkg::ST_OK, 0, 16'hFFFF,
			16'hFFFF, 1, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'h0000, 1, mhpq_pkg::ST_OK, 0, 16'hFFFF, 0, 2, 0);
		add_row(mhpq_pkg::OP_EXTRACT, 16'h0000, 1, mhpq_pkg::ST_OK, 16'hFFFF, 0, 0, 1, 0);
		add_row(mhpq_pkg::OP_EXTRACT, 16'hFFFF, 1, mhpq_pkg::ST_OK, 0, 0, 0, 0, 1);
		add_row(mhpq_pkg::OP_EXTRACT, 16'h5A5A, 1, mhpq_pkg::ST_EMPTY, 0, 0, 0, 0, 1);
		add_row(mhpq_pkg::OP_INSERT, 16'h1234, 1, mhpq_pkg::ST_OK, 0, 16'h1234,
			16'h1234, 1, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'h1234, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'h1234, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'h8000, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'h7FFF, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'h0001, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'h8000, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_EXTRACT, 16'h0000, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_EXTRACT, 16'hFFFF, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_EXTRACT, 16'h0000, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'hAAAA, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_INSERT, 16'h5555, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		for (i = 0; i < 6; i++)
			add_row(mhpq_pkg::OP_EXTRACT, 16'hFFFF, 0, mhpq_pkg::ST_OK, 0, 0, 0, 0, 0);
		add_row(mhpq_pkg::OP_EXTRACT, 16'h0000, 1, mhpq_pkg::ST_EMPTY, 0, 0, 0, 0, 1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed_rows.size(); i++)
			send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
				directed_rows[i].res);

		// random mix, with a stretch of back-to-back traffic in the middle
		run_mixed(120);
		burst_mode = 1'b1;
		run_mixed(60);
		burst_mode = 1'b0;
		run_mixed(150);

		// sender holds off until every outstanding result has come back
		in_valid <= 1'b0;
		wait_drained();

		// drain whatever is held, then extract past empty
		while (heap_fill > 0)
			send_random(8);
		repeat (4) send_random(0);

		run_mixed(250);
		in_valid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			error_count++;
		end

		$display("requests %0d, results %0d, dropped inserts at full %0d, extracts on empty %0d",
			requests_sent, results_seen, full_drops, empty_pops);
		$display("mismatches %0d over %0d cycles", error_count, cycle_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
src/mhpq_pkg.sv
src/mhpq_cell.sv
src/max_heap_priority_queue_unit.sv
src/mhpq_checker.sv
tb/tb_max_heap_priority_queue_unit.sv
